/* src/matrix_multiply_core_defines.svh */
// ----------------------------------------------------------------------------
// matrix multiply core assertion macros
// shared concurrent assertion forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/mm_pkg.sv */
// ----------------------------------------------------------------------------
// mm_pkg
// shared constants, payload types and helpers of the matrix multiply core
// ----------------------------------------------------------------------------
package mm_pkg;

   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 16;

   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int ADDR_W  = $clog2(MAX_DIM * MAX_DIM);
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int DATA_W  = 32;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int ACC_W   = PROD_W + $clog2(MAX_DIM) + 1;
   localparam int CFG_W   = 4;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // request codes
   localparam logic [1:0] REQ_LOAD_LEFT  = 2'd0;
   localparam logic [1:0] REQ_LOAD_RIGHT = 2'd1;
   localparam logic [1:0] REQ_COMPUTE    = 2'd2;

   // register indexes (word address)
   localparam logic [1:0] CSR_LEFT_ROWS  = 2'd0;
   localparam logic [1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [1:0] CSR_RIGHT_COLS = 2'd2;

   typedef struct packed {
      logic [1:0]              req_type;
      logic [2:0]              row_index;
      logic [2:0]              col_index;
      logic signed [DATA_W-1:0] elem_value;
   } mm_req_type;

   typedef struct packed {
      logic [2:0]              out_row;
      logic [2:0]              out_col;
      logic signed [DATA_W-1:0] out_value;
      logic                    overflow;
      logic                    last;
   } mm_rsp_type;

   // one inner-product step travelling with the operand reads
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last_k;
      logic             final_elem;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } mm_step_type;

   function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         res = DIM_W'(MAX_DIM);
      end else begin
         res = DIM_W'(v);
      end
      return res;
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
   endfunction

endpackage

/* src/mm_ram.sv */
// ----------------------------------------------------------------------------
// mm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mm_mac.sv */
// ----------------------------------------------------------------------------
// mm_mac
// multiply, accumulate and saturate datapath, one inner step per cycle
// ----------------------------------------------------------------------------
module mm_mac (
   input  logic                           clock,
   input  logic                           reset,
   input  mm_pkg::mm_step_type            step,
   input  logic signed [mm_pkg::DATA_W-1:0] left_val,
   input  logic signed [mm_pkg::DATA_W-1:0] right_val,
   output logic                           rsp_strobe,
   output mm_pkg::mm_rsp_type             rsp_data
);

   mm_pkg::mm_step_type                     s1_step_ff, s2_step_ff;
   logic signed [mm_pkg::PROD_W-1:0]        prod_ff;
   logic signed [mm_pkg::ACC_W-1:0]         acc_ff, acc_in, prod_ext;
   logic signed [mm_pkg::ACC_W-1:0]         shifted;
   logic [mm_pkg::ACC_W-mm_pkg::DATA_W:0]   hi_bits;
   logic                                    fits;
   logic                                    rsp_strobe_ff;
   mm_pkg::mm_rsp_type                      rsp_data_ff, rsp_data_in;

   // stage 1: product register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_step_ff <= '0;
      end else begin
         s1_step_ff <= step;
      end
      prod_ff <= left_val * right_val;
   end

   assign prod_ext = {{(mm_pkg::ACC_W-mm_pkg::PROD_W){prod_ff[mm_pkg::PROD_W-1]}}, prod_ff};

   always_comb begin
      if (s1_step_ff.first) begin
         acc_in = prod_ext;
      end else begin
         acc_in = acc_ff + prod_ext;
      end
   end

   // stage 2: accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_step_ff <= '0;
      end else begin
         s2_step_ff <= s1_step_ff;
      end
      if (s1_step_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // floor shift then saturate to the result width
   assign shifted = acc_ff >>> mm_pkg::FRAC_BITS;
   assign hi_bits = shifted[mm_pkg::ACC_W-1:mm_pkg::DATA_W-1];
   assign fits    = (&hi_bits) | ~(|hi_bits);

   always_comb begin
      rsp_data_in.out_row = 3'(s2_step_ff.row);
      rsp_data_in.out_col = 3'(s2_step_ff.col);
      rsp_data_in.last    = s2_step_ff.final_elem;
      rsp_data_in.overflow = ~fits;
      if (fits) begin
         rsp_data_in.out_value = shifted[mm_pkg::DATA_W-1:0];
      end else if (acc_ff[mm_pkg::ACC_W-1]) begin
         rsp_data_in.out_value = {1'b1, {(mm_pkg::DATA_W-1){1'b0}}};
      end else begin
         rsp_data_in.out_value = {1'b0, {(mm_pkg::DATA_W-1){1'b1}}};
      end
   end

   // stage 3: result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s2_step_ff.valid & s2_step_ff.last_k;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

/* src/matrix_multiply_core.sv */
// ----------------------------------------------------------------------------
// matrix_multiply_core
// loads: written straight into the left or right ram
// compute: one result per inner_size operand reads, paced by the single
//   ram read port per store
// busy stays high until the cycle after the last result; results cannot stall
// reset: synchronous, sizes go to 8, store contents stay undefined
// ----------------------------------------------------------------------------
`include "matrix_multiply_core_defines.svh"

module matrix_multiply_core (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               start,
   output logic                               busy,
   input  mm_pkg::mm_req_type                 req_data,
   // result channel
   output logic                               rsp_strobe,
   output mm_pkg::mm_rsp_type                 rsp_data,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                               pready
);

   // size registers
   logic [mm_pkg::CFG_W-1:0] left_rows_ff, inner_size_ff, right_cols_ff;
   logic                     csr_wr;
   logic [1:0]               csr_idx;

   // run sizes, latched when a compute is taken
   logic [mm_pkg::DIM_W-1:0] nr, nk, nc;
   logic [mm_pkg::DIM_W-1:0] run_nr_ff, run_nk_ff, run_nc_ff;

   // sequencer counters
   logic                     busy_ff, busy_in;
   logic                     issuing_ff, issuing_in;
   logic [mm_pkg::IDX_W-1:0] r_ff, c_ff, k_ff, r_in, c_in, k_in;
   logic                     k_end, c_end, r_end;
   mm_pkg::mm_step_type      step_now, step_ff;

   // request decode
   logic                     accept;
   logic                     take_left, take_right, take_compute;
   logic                     left_ok, right_ok;
   logic [mm_pkg::ADDR_W-1:0] wr_addr;

   logic signed [mm_pkg::DATA_W-1:0] left_rd, right_rd;

   // ------------------------------------------------------------------
   // register port: always ready, word-addressed
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= mm_pkg::CFG_W'(mm_pkg::MAX_DIM);
         inner_size_ff <= mm_pkg::CFG_W'(mm_pkg::MAX_DIM);
         right_cols_ff <= mm_pkg::CFG_W'(mm_pkg::MAX_DIM);
      end else if (csr_wr) begin
         case (csr_idx)
            mm_pkg::CSR_LEFT_ROWS:  left_rows_ff  <= pwdata[mm_pkg::CFG_W-1:0];
            mm_pkg::CSR_INNER_SIZE: inner_size_ff <= pwdata[mm_pkg::CFG_W-1:0];
            mm_pkg::CSR_RIGHT_COLS: right_cols_ff <= pwdata[mm_pkg::CFG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mm_pkg::CSR_LEFT_ROWS:  prdata = mm_pkg::CSR_DATA_W'(left_rows_ff);
         mm_pkg::CSR_INNER_SIZE: prdata = mm_pkg::CSR_DATA_W'(inner_size_ff);
         mm_pkg::CSR_RIGHT_COLS: prdata = mm_pkg::CSR_DATA_W'(right_cols_ff);
         default:                prdata = '0;
      endcase
   end

   // zero acts as one, oversize clips to the store dimension
   assign nr = mm_pkg::eff_size(left_rows_ff);
   assign nk = mm_pkg::eff_size(inner_size_ff);
   assign nc = mm_pkg::eff_size(right_cols_ff);

   // ------------------------------------------------------------------
   // request decode: loads outside the configured sizes are dropped
   // ------------------------------------------------------------------
   assign accept   = start & ~busy_ff;
   assign left_ok  = (mm_pkg::DIM_W'(req_data.row_index) < nr) &&
                     (mm_pkg::DIM_W'(req_data.col_index) < nk);
   assign right_ok = (mm_pkg::DIM_W'(req_data.row_index) < nk) &&
                     (mm_pkg::DIM_W'(req_data.col_index) < nc);

   assign take_left    = accept && (req_data.req_type == mm_pkg::REQ_LOAD_LEFT) && left_ok;
   assign take_right   = accept && (req_data.req_type == mm_pkg::REQ_LOAD_RIGHT) && right_ok;
   assign take_compute = accept && (req_data.req_type == mm_pkg::REQ_COMPUTE);

   assign wr_addr = mm_pkg::addr_of(mm_pkg::IDX_W'(req_data.row_index),
                                    mm_pkg::IDX_W'(req_data.col_index));

   // ------------------------------------------------------------------
   // sequencer: walks k inside c inside r, one operand pair per cycle
   // ------------------------------------------------------------------
   assign k_end = (mm_pkg::DIM_W'(k_ff) == run_nk_ff - mm_pkg::DIM_W'(1));
   assign c_end = (mm_pkg::DIM_W'(c_ff) == run_nc_ff - mm_pkg::DIM_W'(1));
   assign r_end = (mm_pkg::DIM_W'(r_ff) == run_nr_ff - mm_pkg::DIM_W'(1));

   always_comb begin
      r_in       = r_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      issuing_in = issuing_ff;
      if (take_compute) begin
         r_in       = '0;
         c_in       = '0;
         k_in       = '0;
         issuing_in = 1'b1;
      end else if (issuing_ff) begin
         if (!k_end) begin
            k_in = k_ff + mm_pkg::IDX_W'(1);
         end else begin
            k_in = '0;
            if (!c_end) begin
               c_in = c_ff + mm_pkg::IDX_W'(1);
            end else begin
               c_in = '0;
               if (!r_end) begin
                  r_in = r_ff + mm_pkg::IDX_W'(1);
               end else begin
                  issuing_in = 1'b0;
               end
            end
         end
      end
   end

   // busy drops once the flagged last result has been shown
   always_comb begin
      busy_in = busy_ff;
      if (take_compute) begin
         busy_in = 1'b1;
      end else if (rsp_strobe && rsp_data.last) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      step_now.valid      = issuing_ff;
      step_now.first      = (k_ff == '0);
      step_now.last_k     = k_end;
      step_now.final_elem = k_end & c_end & r_end;
      step_now.row        = r_ff;
      step_now.col        = c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         issuing_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         busy_ff    <= busy_in;
         issuing_ff <= issuing_in;
         step_ff    <= step_now;
      end
      r_ff <= r_in;
      c_ff <= c_in;
      k_ff <= k_in;
      if (take_compute) begin
         run_nr_ff <= nr;
         run_nk_ff <= nk;
         run_nc_ff <= nc;
      end
   end

   assign busy = busy_ff;

   // ------------------------------------------------------------------
   // operand stores; loads are locked out while busy, so a read never
   // meets a write to the same entry
   // ------------------------------------------------------------------
   mm_ram #(
      .WIDTH (mm_pkg::DATA_W),
      .DEPTH (mm_pkg::DEPTH)
   ) u_left_ram (
      .clock   (clock),
      .wr_en   (take_left),
      .wr_addr (wr_addr),
      .wr_data (req_data.elem_value),
      .rd_addr (mm_pkg::addr_of(r_ff, k_ff)),
      .rd_data (left_rd)
   );

   mm_ram #(
      .WIDTH (mm_pkg::DATA_W),
      .DEPTH (mm_pkg::DEPTH)
   ) u_right_ram (
      .clock   (clock),
      .wr_en   (take_right),
      .wr_addr (wr_addr),
      .wr_data (req_data.elem_value),
      .rd_addr (mm_pkg::addr_of(k_ff, c_ff)),
      .rd_data (right_rd)
   );

   // ------------------------------------------------------------------
   // datapath: step_ff lines up with the registered ram outputs
   // ------------------------------------------------------------------
   mm_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .step       (step_ff),
      .left_val   (left_rd),
      .right_val  (right_rd),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `MM_ASSERT_SAME(a_strobe_while_busy, rsp_strobe, busy_ff, "result outside a compute")
   `MM_ASSERT_SAME(a_issue_while_busy, issuing_ff, busy_ff, "operand read while idle")
   `MM_ASSERT_NEXT(a_idle_after_last, rsp_strobe && rsp_data.last, !busy_ff && !issuing_ff, "busy held past last result")
   `MM_ASSERT_NEXT(a_busy_after_compute, take_compute, busy_ff && issuing_ff, "compute taken without starting")

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// matrix multiply core testbench
// loads left and right matrices through the request channel, runs compute
// requests under many size settings and checks every product element, in
// order and field by field, against a Q16.16 multiply-accumulate predictor
// ----------------------------------------------------------------------------
module testbench;
   import mm_pkg::*;

   // run control
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4 + MAX_DIM + 4;
   localparam int RANDOM_ITEMS  = 180;
   localparam int GAP_PERCENT   = 20;
   localparam int MAX_REPORTS   = 100;

   // request code the block must ignore
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   // register index past the end of the register list
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // accumulator wide enough for eight full-scale products
   localparam int ACC_BITS = 72;
   localparam logic signed [ACC_BITS-1:0] SAT_HIGH = 72'sd2147483647;
   localparam logic signed [ACC_BITS-1:0] SAT_LOW  = -SAT_HIGH - 1;

   // Q16.16 corner values
   localparam logic signed [DATA_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN      = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_ONE      = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q_ONE_HALF = 32'sh0001_8000;
   localparam logic signed [DATA_W-1:0] Q_NEG_LSB  = -32'sd1;
   localparam logic signed [DATA_W-1:0] Q_LSB      = 32'sd1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   mm_req_type            req_data;
   logic                  rsp_strobe;
   mm_rsp_type            rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // predictor copy of the stores and the size registers
   logic signed [DATA_W-1:0] left_mat  [DEPTH];
   logic signed [DATA_W-1:0] right_mat [DEPTH];
   bit                       left_loaded  [DEPTH];
   bit                       right_loaded [DEPTH];
   logic [CFG_W-1:0]         rows_cfg  = CFG_W'(8);
   logic [CFG_W-1:0]         inner_cfg = CFG_W'(8);
   logic [CFG_W-1:0]         cols_cfg  = CFG_W'(8);

   // product elements still to come, oldest first
   mm_rsp_type pending_products[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   int  items_accepted = 0;
   bit  gaps_enabled   = 1'b1;

   matrix_multiply_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #2 clock = ~clock;

   // watchdog: a hung handshake or a missing result ends here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d product elements outstanding",
                  cycle_count, pending_products.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // size register as the block uses it: zero acts as one, past MAX_DIM clamps
   function automatic int dim_in_use(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return 1;
      end else if (int'(v) > MAX_DIM) begin
         return MAX_DIM;
      end
      return int'(v);
   endfunction

   // one product element: exact sum of products, floor shift, saturate
   function automatic mm_rsp_type product_element(input int r, input int c, input int nr,
                                                  input int nk, input int nc);
      mm_rsp_type                  elem;
      logic signed [ACC_BITS-1:0] sum;
      logic signed [ACC_BITS-1:0] shifted;
      logic signed [ACC_BITS-1:0] lhs;
      logic signed [ACC_BITS-1:0] rhs;
      sum = '0;
      for (int k = 0; k < nk; k++) begin
         lhs = left_mat[r * MAX_DIM + k];
         rhs = right_mat[k * MAX_DIM + c];
         sum = sum + lhs * rhs;
      end
      shifted = sum >>> FRAC_BITS;
      elem.out_row = 3'(r);
      elem.out_col = 3'(c);
      if (shifted > SAT_HIGH) begin
         elem.out_value = Q_MAX;
         elem.overflow  = 1'b1;
      end else if (shifted < SAT_LOW) begin
         elem.out_value = Q_MIN;
         elem.overflow  = 1'b1;
      end else begin
         elem.out_value = shifted[DATA_W-1:0];
         elem.overflow  = 1'b0;
      end
      elem.last = (r == nr - 1) && (c == nc - 1);
      return elem;
   endfunction

   // apply one accepted item to the predictor
   task automatic predict_item(input mm_req_type item);
      int nr;
      int nk;
      int nc;
      int slot;
      nr   = dim_in_use(rows_cfg);
      nk   = dim_in_use(inner_cfg);
      nc   = dim_in_use(cols_cfg);
      slot = int'(item.row_index) * MAX_DIM + int'(item.col_index);
      case (item.req_type)
         REQ_LOAD_LEFT: begin
            // loads outside the left matrix are dropped
            if (int'(item.row_index) < nr && int'(item.col_index) < nk) begin
               left_mat[slot]    = item.elem_value;
               left_loaded[slot] = 1'b1;
            end
         end
         REQ_LOAD_RIGHT: begin
            if (int'(item.row_index) < nk && int'(item.col_index) < nc) begin
               right_mat[slot]    = item.elem_value;
               right_loaded[slot] = 1'b1;
            end
         end
         REQ_COMPUTE: begin
            // row-major walk of the product
            for (int r = 0; r < nr; r++) begin
               for (int c = 0; c < nc; c++) begin
                  pending_products.push_back(product_element(r, c, nr, nk, nc));
               end
            end
         end
         default: begin
            // unknown request: no effect, no result
         end
      endcase
   endtask

   function automatic mm_req_type make_item(input logic [1:0] kind, input logic [2:0] row,
                                            input logic [2:0] col,
                                            input logic signed [DATA_W-1:0] value);
      mm_req_type item;
      item.req_type   = kind;
      item.row_index  = row;
      item.col_index  = col;
      item.elem_value = value;
      return item;
   endfunction

   // mostly small Q16.16 values so sums stay in range, some corners and raw words
   function automatic logic signed [DATA_W-1:0] random_element();
      logic [DATA_W-1:0] raw;
      raw = $urandom;
      case ($urandom_range(0, 9))
         0: return raw;
         1: begin
            case ($urandom_range(0, 4))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return Q_NEG_LSB;
               3: return Q_ONE;
               default: return '0;
            endcase
         end
         default: return {{12{raw[19]}}, raw[19:0]};
      endcase
   endfunction

   // one item through the start/busy handshake, random idle cycles ahead of it if gaps_enabled
   task automatic send_item(input mm_req_type item);
      if (gaps_enabled) begin
         while ($urandom_range(0, 99) < GAP_PERCENT) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= item;
      // accepted at the first edge that sees busy low
      do @(posedge clock); while (busy !== 1'b0);
      predict_item(item);
      items_accepted++;
   endtask

   // drop start, let every expected element arrive, then let the block settle
   task automatic wait_products_done();
      start <= 1'b0;
      while (pending_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // setup phase then access phase; the write lands at the access edge with pready
   task automatic write_register(input logic [1:0] index, input logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {28'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      case (index)
         CSR_LEFT_ROWS:  rows_cfg  = value;
         CSR_INNER_SIZE: inner_cfg = value;
         CSR_RIGHT_COLS: cols_cfg  = value;
         default: begin
            // index past the register list is ignored
         end
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_register(input logic [1:0] index, output logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      value = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_register(input logic [1:0] index, input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      read_register(index, got);
      if (got[CFG_W-1:0] !== want) begin
         report_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                   index, got[CFG_W-1:0], want));
      end
   endtask

   task automatic set_sizes(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                            input logic [CFG_W-1:0] cols);
      write_register(CSR_LEFT_ROWS, rows);
      write_register(CSR_INNER_SIZE, inner);
      write_register(CSR_RIGHT_COLS, cols);
   endtask

   // every entry the next compute reads must have been loaded once
   task automatic load_missing_entries();
      int nr;
      int nk;
      int nc;
      nr = dim_in_use(rows_cfg);
      nk = dim_in_use(inner_cfg);
      nc = dim_in_use(cols_cfg);
      for (int r = 0; r < nr; r++) begin
         for (int k = 0; k < nk; k++) begin
            if (!left_loaded[r * MAX_DIM + k]) begin
               send_item(make_item(REQ_LOAD_LEFT, 3'(r), 3'(k), random_element()));
            end
         end
      end
      for (int k = 0; k < nk; k++) begin
         for (int c = 0; c < nc; c++) begin
            if (!right_loaded[k * MAX_DIM + c]) begin
               send_item(make_item(REQ_LOAD_RIGHT, 3'(k), 3'(c), random_element()));
            end
         end
      end
   endtask

   // a few loads (some out of range, some unknown codes), top up, then compute
   task automatic run_job();
      int nr;
      int nk;
      int nc;
      int pick;
      nr = dim_in_use(rows_cfg);
      nk = dim_in_use(inner_cfg);
      nc = dim_in_use(cols_cfg);
      repeat ($urandom_range(4, 12)) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            send_item(make_item(REQ_LOAD_LEFT, 3'($urandom_range(0, nr - 1)),
                                3'($urandom_range(0, nk - 1)), random_element()));
         end else if (pick < 80) begin
            send_item(make_item(REQ_LOAD_RIGHT, 3'($urandom_range(0, nk - 1)),
                                3'($urandom_range(0, nc - 1)), random_element()));
         end else if (pick < 92) begin
            // any index at all, so many of these fall outside and get dropped
            send_item(make_item(pick[0] ? REQ_LOAD_LEFT : REQ_LOAD_RIGHT,
                                3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                random_element()));
         end else begin
            send_item(make_item(REQ_UNKNOWN, 3'($urandom_range(0, 7)),
                                3'($urandom_range(0, 7)), $urandom));
         end
      end
      load_missing_entries();
      // index and value fields of a compute are don't-care, so randomize them
      send_item(make_item(REQ_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                          $urandom));
   endtask

   // mostly small sizes, now and then anything the register holds
   function automatic logic [CFG_W-1:0] pick_size();
      if ($urandom_range(0, 99) < 80) begin
         return CFG_W'($urandom_range(0, 4));
      end
      return CFG_W'($urandom_range(0, 15));
   endfunction

   // reset values, both register extremes, and a write past the register list
   task automatic test_register_access();
      check_register(CSR_LEFT_ROWS, CFG_W'(8));
      check_register(CSR_INNER_SIZE, CFG_W'(8));
      check_register(CSR_RIGHT_COLS, CFG_W'(8));
      set_sizes(CFG_W'(0), CFG_W'(0), CFG_W'(0));
      check_register(CSR_LEFT_ROWS, CFG_W'(0));
      check_register(CSR_INNER_SIZE, CFG_W'(0));
      check_register(CSR_RIGHT_COLS, CFG_W'(0));
      set_sizes(CFG_W'(15), CFG_W'(15), CFG_W'(15));
      write_register(CSR_UNUSED, CFG_W'(5));
      check_register(CSR_LEFT_ROWS, CFG_W'(15));
      check_register(CSR_INNER_SIZE, CFG_W'(15));
      check_register(CSR_RIGHT_COLS, CFG_W'(15));
   endtask

   // 2x2 by 2x2 with corner values: saturation both ways and a floored result
   task automatic test_directed_products();
      set_sizes(CFG_W'(2), CFG_W'(2), CFG_W'(2));
      send_item(make_item(REQ_LOAD_LEFT, 3'd0, 3'd0, Q_MAX));
      send_item(make_item(REQ_LOAD_LEFT, 3'd0, 3'd1, Q_MIN));
      send_item(make_item(REQ_LOAD_LEFT, 3'd1, 3'd0, Q_NEG_LSB));
      send_item(make_item(REQ_LOAD_LEFT, 3'd1, 3'd1, Q_ONE));
      send_item(make_item(REQ_LOAD_RIGHT, 3'd0, 3'd0, Q_MAX));
      send_item(make_item(REQ_LOAD_RIGHT, 3'd0, 3'd1, Q_LSB));
      send_item(make_item(REQ_LOAD_RIGHT, 3'd1, 3'd0, Q_MIN));
      send_item(make_item(REQ_LOAD_RIGHT, 3'd1, 3'd1, Q_ONE_HALF));
      send_item(make_item(REQ_COMPUTE, 3'd0, 3'd0, '0));
      wait_products_done();
   endtask

   // loads past the configured sizes and unknown codes must leave the stores alone
   task automatic test_dropped_requests();
      send_item(make_item(REQ_LOAD_LEFT, 3'd2, 3'd0, '0));
      send_item(make_item(REQ_LOAD_LEFT, 3'd0, 3'd2, '0));
      send_item(make_item(REQ_LOAD_RIGHT, 3'd2, 3'd1, '0));
      send_item(make_item(REQ_LOAD_RIGHT, 3'd7, 3'd7, '0));
      send_item(make_item(REQ_UNKNOWN, 3'd0, 3'd0, Q_ONE));
      send_item(make_item(REQ_COMPUTE, 3'd7, 3'd7, Q_MIN));
      wait_products_done();
   endtask

   // zero acts as one, values past MAX_DIM act as MAX_DIM
   task automatic test_size_clamping();
      set_sizes(CFG_W'(0), CFG_W'(0), CFG_W'(0));
      send_item(make_item(REQ_COMPUTE, 3'd0, 3'd0, '0));
      wait_products_done();
      set_sizes(CFG_W'(15), CFG_W'(1), CFG_W'(0));
      // left column zero, rows two to seven, the last at the top index
      for (int r = 2; r < MAX_DIM; r++) begin
         send_item(make_item(REQ_LOAD_LEFT, 3'(r), 3'd0, random_element()));
      end
      send_item(make_item(REQ_COMPUTE, 3'd0, 3'd0, '0));
      wait_products_done();
   endtask

   // random jobs across many size settings; the first phase runs without gaps
   task automatic test_random_products();
      int target;
      int phase;
      target = items_accepted + RANDOM_ITEMS;
      phase  = 0;
      while (phase < 4 || items_accepted < target) begin
         case (phase)
            0: begin
               gaps_enabled = 1'b0;
               set_sizes(CFG_W'(15), CFG_W'(9), CFG_W'(15));
            end
            1: begin
               gaps_enabled = 1'b1;
               set_sizes(CFG_W'(1), CFG_W'(1), CFG_W'(1));
            end
            2: set_sizes(CFG_W'(8), CFG_W'(8), CFG_W'(8));
            3: set_sizes(CFG_W'(0), CFG_W'(8), CFG_W'(2));
            default: set_sizes(pick_size(), pick_size(), pick_size());
         endcase
         repeat (2) run_job();
         wait_products_done();
         phase++;
      end
   endtask

   // every strobed element against the oldest expected one
   always @(posedge clock) begin : check_products
      mm_rsp_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_products.size() == 0) begin
            report_mismatch($sformatf("unexpected product element row %0d col %0d",
                                      rsp_data.out_row, rsp_data.out_col));
         end else begin
            want = pending_products.pop_front();
            if (rsp_data.out_row !== want.out_row) begin
               report_mismatch($sformatf("out_row %0d, expected %0d",
                                         rsp_data.out_row, want.out_row));
            end
            if (rsp_data.out_col !== want.out_col) begin
               report_mismatch($sformatf("out_col %0d, expected %0d",
                                         rsp_data.out_col, want.out_col));
            end
            if (rsp_data.out_value !== want.out_value) begin
               report_mismatch($sformatf("out_value %h at (%0d,%0d), expected %h",
                                         rsp_data.out_value, want.out_row, want.out_col,
                                         want.out_value));
            end
            if (rsp_data.overflow !== want.overflow) begin
               report_mismatch($sformatf("overflow %b at (%0d,%0d), expected %b",
                                         rsp_data.overflow, want.out_row, want.out_col,
                                         want.overflow));
            end
            if (rsp_data.last !== want.last) begin
               report_mismatch($sformatf("last %b at (%0d,%0d), expected %b",
                                         rsp_data.last, want.out_row, want.out_col,
                                         want.last));
            end
         end
      end
   end

   initial begin
      // every input known from time zero
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_register_access();
      test_directed_products();
      test_dropped_requests();
      test_size_clamping();
      test_random_products();
      wait_products_done();

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/mm_pkg.sv
src/mm_ram.sv
src/mm_mac.sv
src/matrix_multiply_core.sv
test/testbench.sv
